FILE: hw/rtl/bit_packet_framer_ones_end_assert.svh
// Assertion macros for the bit packet framer.
// Included by files that carry concurrent assertions; needs no other file.
`ifndef BIT_PACKET_FRAMER_ONES_END_ASSERT_SVH
`define BIT_PACKET_FRAMER_ONES_END_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BPFO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bpfo assertion failed");

`define BPFO_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpfo assertion failed");

`else

`define BPFO_ASSERT(lbl, clk, rstn, prop)

`define BPFO_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hw/rtl/bpfo_pkg.sv
// Shared constants and types for the bit packet framer.
// No dependencies; imported by every module of the block.
package bpfo_pkg;

  localparam int MaxPacketBytes = 32;
  localparam int StoreDepth     = (MaxPacketBytes + 3) / 4 * 4;
  localparam int AddrW          = $clog2(StoreDepth);
  localparam int CntW           = $clog2(StoreDepth + 1);
  localparam int MemAddrW       = AddrW + 1;
  localparam int MemDepth       = 2 ** MemAddrW;

  localparam int RunW      = 3;
  localparam int RunLimit  = 6;
  localparam int SampleW   = 8;
  localparam int DataBit   = 0;
  localparam int SyncBit   = 1;
  localparam int SampleOne = 1;

  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [7:0]          data;
  } wr_t;

  typedef struct packed {
    logic [CntW-1:0] stored;
    logic [CntW-1:0] total;
  } cmd_t;

endpackage

FILE: hw/rtl/bpfo_front.sv
// Front end of the framer: takes samples, finds sync, assembles bytes and ends packets.
// Depends on bpfo_pkg; writes bytes to the back end and pushes one command per packet.
module bpfo_front
  import bpfo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [SampleW-1:0] sample_i,
  input  logic               done_i,
  output wr_t                wr_o,
  output logic               cmd_push_o,
  output cmd_t               cmd_o
);

  logic            in_packet_q, in_packet_d;
  logic [6:0]      shift_q, shift_d;
  logic [2:0]      bitpos_q, bitpos_d;
  logic [CntW-1:0] stored_q, stored_d;
  logic [RunW-1:0] run_q, run_d;
  logic            bank_q, bank_d;
  logic [1:0]      pkts_q, pkts_d;

  logic            accept;
  logic            active;
  logic [6:0]      shift_base;
  logic [2:0]      bitpos_base;
  logic [CntW-1:0] stored_base;
  logic [RunW-1:0] run_base;
  logic [RunW-1:0] run_n;
  logic [7:0]      byte_w;
  logic            byte_done;
  logic [CntW-1:0] stored_n;
  logic [CntW:0]   total_sum;
  logic            pkt_end;

  assign full   = !in_packet_q && (pkts_q == 2'd2);
  assign accept = push && !full;

  always_comb begin
    active      = accept && (in_packet_q || sample_i[SyncBit]);
    shift_base  = in_packet_q ? shift_q : '0;
    bitpos_base = in_packet_q ? bitpos_q : '0;
    stored_base = in_packet_q ? stored_q : '0;
    run_base    = in_packet_q ? run_q : '0;
    byte_w      = {shift_base, sample_i[DataBit]};
    run_n       = run_base;
    if (sample_i == SampleW'(SampleOne)) begin
      if (run_base < RunW'(RunLimit)) begin
        run_n = run_base + 1'b1;
      end
    end else if (run_base < RunW'(RunLimit)) begin
      run_n = '0;
    end
    byte_done = (bitpos_base == 3'd7);
    stored_n  = stored_base + 1'b1;
    total_sum = {1'b0, stored_n} + (CntW + 1)'(3);
    pkt_end   = byte_done && ((run_n == RunW'(RunLimit)) ||
                              (stored_n == CntW'(MaxPacketBytes)));

    wr_o.en   = active && byte_done;
    wr_o.addr = {bank_q, stored_base[AddrW-1:0]};
    wr_o.data = byte_w;

    cmd_push_o   = active && pkt_end;
    cmd_o.stored = stored_n;
    cmd_o.total  = {total_sum[CntW-1:2], 2'b00};

    in_packet_d = in_packet_q;
    shift_d     = shift_q;
    bitpos_d    = bitpos_q;
    stored_d    = stored_q;
    run_d       = run_q;
    if (active) begin
      in_packet_d = !pkt_end;
      shift_d     = byte_w[6:0];
      bitpos_d    = bitpos_base + 1'b1;
      run_d       = run_n;
      stored_d    = byte_done ? stored_n : stored_base;
    end

    bank_d = cmd_push_o ? !bank_q : bank_q;
    pkts_d = pkts_q + {1'b0, cmd_push_o} - {1'b0, done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      shift_q     <= '0;
      bitpos_q    <= '0;
      stored_q    <= '0;
      run_q       <= '0;
      bank_q      <= 1'b0;
      pkts_q      <= '0;
    end else begin
      in_packet_q <= in_packet_d;
      shift_q     <= shift_d;
      bitpos_q    <= bitpos_d;
      stored_q    <= stored_d;
      run_q       <= run_d;
      bank_q      <= bank_d;
      pkts_q      <= pkts_d;
    end
  end

endmodule

FILE: hw/rtl/bpfo_cmd_fifo.sv
// Two-entry queue of packet commands between the front and back ends.
// Depends on bpfo_pkg for the command type.
module bpfo_cmd_fifo
  import bpfo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/bpfo_back.sv
// Back end of the framer: double-banked packet store and byte-by-byte readout with padding.
// Depends on bpfo_pkg; takes commands from bpfo_cmd_fifo and writes from bpfo_front.
module bpfo_back
  import bpfo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wr_t        wr_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       done_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] packet_byte_o,
  output logic       last_byte_o
);

  logic [7:0]      mem [MemDepth];
  logic            busy_q, busy_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] stored_q, stored_d;
  logic [CntW-1:0] total_q, total_d;
  logic            bank_q, bank_d;
  logic            valid_q, valid_d;
  logic [7:0]      data_q;
  logic            pad_q;
  logic            last_q;

  logic                out_ld;
  logic                rd_en;
  logic                is_last;
  logic [MemAddrW-1:0] rd_addr;

  assign empty         = !valid_q;
  assign packet_byte_o = pad_q ? 8'h00 : data_q;
  assign last_byte_o   = last_q;

  always_comb begin
    cmd_pop_o = !busy_q && cmd_valid_i;
    out_ld    = !valid_q || pop;
    rd_en     = busy_q && out_ld;
    is_last   = (ptr_q == total_q - 1'b1);
    rd_addr   = {bank_q, ptr_q[AddrW-1:0]};
    done_o    = rd_en && is_last;

    busy_d   = busy_q;
    ptr_d    = ptr_q;
    stored_d = stored_q;
    total_d  = total_q;
    bank_d   = bank_q;
    if (cmd_pop_o) begin
      busy_d   = 1'b1;
      ptr_d    = '0;
      stored_d = cmd_i.stored;
      total_d  = cmd_i.total;
    end else if (rd_en) begin
      ptr_d = ptr_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
        bank_d = !bank_q;
      end
    end

    if (rd_en) begin
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
      pad_q  <= (ptr_q >= stored_q);
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ptr_q    <= '0;
      stored_q <= '0;
      total_q  <= '0;
      bank_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ptr_q    <= ptr_d;
      stored_q <= stored_d;
      total_q  <= total_d;
      bank_q   <= bank_d;
      valid_q  <= valid_d;
    end
  end

endmodule

FILE: hw/rtl/bit_packet_framer_ones_end.sv
// Top level of the bit packet framer: front end, command queue and back end.
// Depends on bpfo_pkg, bpfo_front, bpfo_cmd_fifo, bpfo_back and the assertion header.
//
// Channel   Direction  Handshake     Fields
// samples   in         push / full   sample_i[7:0]
// packets   out        empty / pop   packet_byte_o[7:0], last_byte_o
//
// One sample is taken per cycle while full is low.
// When the back end is idle, the command of a packet passes through the command queue and the back end's
// busy state, and its first byte is then registered for output; then one byte per cycle while pop keeps up,
// with a gap between packets; the single read port of the double-banked packet store sets that rate.
// Two packets may wait for readout; full is high while both wait and no packet is open.
// Reset clears all control state at once; the packet store needs no clearing.
`include "bit_packet_framer_ones_end_assert.svh"

module bit_packet_framer_ones_end
  import bpfo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [SampleW-1:0] sample_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         packet_byte_o,
  output logic               last_byte_o
);

  wr_t  wr;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_out;
  logic done;

  bpfo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .done_i     (done),
    .wr_o       (wr),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  bpfo_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  bpfo_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .done_o        (done),
    .empty         (empty),
    .pop           (pop),
    .packet_byte_o (packet_byte_o),
    .last_byte_o   (last_byte_o)
  );

  // A packet can only end on the transfer that completes and stores a byte.
  `BPFO_ASSERT(a_end_on_byte, clk_i, rst_ni, cmd_push |-> wr.en)
  // Reading the final byte of a packet puts a flagged last byte on the outputs.
  `BPFO_ASSERT(a_done_shows_last, clk_i, rst_ni, done |=> (!empty && last_byte_o))
  // The input only stalls right after a packet has been handed over.
  `BPFO_ASSERT(a_full_after_end, clk_i, rst_ni, $rose(full) |-> $past(cmd_push))

endmodule

FILE: verif/bit_packet_framer_ones_end_test.sv
// Self-checking testbench for the bit packet framer with a run-of-ones packet end.
// Needs bpfo_pkg and the bit_packet_framer_ones_end RTL; reads no files.
`timescale 1ns / 1ps

module bit_packet_framer_ones_end_test;
  import bpfo_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } packet_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [SampleW-1:0] sample_i;
  logic               empty;
  logic               pop;
  logic [7:0]         packet_byte_o;
  logic               last_byte_o;

  // Predicted state of the framer.
  logic       framing;
  logic [7:0] shift_reg;
  logic [2:0] bit_cnt;
  int         stored_cnt;
  logic [2:0] run_cnt;
  logic [7:0] frame_buf [StoreDepth];

  packet_byte_t expected_bytes [$];
  int framed_samples;
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;

  bit_packet_framer_ones_end dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .empty         (empty),
    .pop           (pop),
    .packet_byte_o (packet_byte_o),
    .last_byte_o   (last_byte_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void frame_sample(input logic [7:0] s);
    int n;
    if (!framing) begin
      if (!s[SyncBit]) return;
      framing = 1'b1;
      shift_reg = '0;
      bit_cnt = '0;
      stored_cnt = 0;
      run_cnt = '0;
    end
    framed_samples++;
    shift_reg = {shift_reg[6:0], s[DataBit]};
    if (s == SampleOne) begin
      if (run_cnt < RunLimit) run_cnt++;
    end else if (run_cnt < RunLimit) begin
      run_cnt = '0;
    end
    if (bit_cnt != 3'd7) begin
      bit_cnt++;
      return;
    end
    bit_cnt = '0;
    if (stored_cnt < StoreDepth) frame_buf[stored_cnt] = shift_reg;
    stored_cnt++;
    if (run_cnt < RunLimit && stored_cnt != MaxPacketBytes) return;
    while (stored_cnt % 4 != 0) begin
      if (stored_cnt < StoreDepth) frame_buf[stored_cnt] = 8'h00;
      stored_cnt++;
    end
    n = (stored_cnt > StoreDepth) ? StoreDepth : stored_cnt;
    for (int i = 0; i < n; i++) begin
      expected_bytes.push_back('{data: frame_buf[i], is_last: (i + 1 == n)});
    end
    framing = 1'b0;
  endfunction

  task automatic send_sample(input logic [7:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    frame_sample(s);
  endtask

  task automatic check_byte(input logic [7:0] data, input logic is_last);
    packet_byte_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected packet byte %h last %b at cycle %0d", data, is_last, cycles);
      return;
    end
    want = expected_bytes.pop_front();
    if (data !== want.data || is_last !== want.is_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Packet byte mismatch at cycle %0d: expected %h last %b, got %h last %b",
                 cycles, want.data, want.is_last, data, is_last);
    end
  endtask

  // Receiver side: every accepted transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_byte(packet_byte_o, last_byte_o);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_frame(input int nbytes);
    logic [7:0] s;
    int data_len;
    int ones_sent;
    s = 8'($urandom);
    s[SyncBit] = 1'b1;
    send_sample(s);
    data_len = 8 * nbytes - 1 - $urandom_range(6);
    for (int k = 0; k < data_len && framing; k++) begin
      case ($urandom_range(9))
        0, 1: send_sample(8'h01);
        2: send_sample(8'h00);
        3: begin
          // A run of five ones that 8'h03 then breaks, unless ones sent before it already end the packet.
          repeat (5) if (framing) send_sample(8'h01);
          if (framing) send_sample(8'h03);
        end
        default: send_sample(8'($urandom));
      endcase
    end
    ones_sent = 0;
    while (framing) begin
      if (ones_sent < RunLimit) begin
        send_sample(8'h01);
        ones_sent++;
      end else begin
        send_sample(8'($urandom));
      end
    end
  endtask

  task automatic test_ignored_while_searching();
    send_sample(8'h00);
    send_sample(8'hFD);
    send_sample(8'h01);
  endtask

  task automatic test_run_of_ones_end();
    send_sample(8'hFF);
    repeat (6) send_sample(8'h01);
    send_sample(8'h00);
  endtask

  task automatic test_sync_inside_packet();
    send_sample(8'h02);
    send_sample(8'h03);
    repeat (5) send_sample(8'h01);
    send_sample(8'h80);
    repeat (6) send_sample(8'h01);
    send_sample(8'hFE);
    send_sample(8'h00);
  endtask

  task automatic test_max_length_end();
    send_sample(8'h03);
    while (framing) send_sample(8'hF0 | 8'($urandom_range(1)));
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int target);
    logic [7:0] s;
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = framed_samples;
    while (framed_samples - start < target) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) begin
            s = 8'($urandom);
            s[SyncBit] = 1'b0;
            send_sample(s);
          end
        end
        3: send_frame(MaxPacketBytes + 2);
        default: send_frame($urandom_range(1, 6));
      endcase
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    sample_i <= '0;
    framing = 1'b0;
    shift_reg = '0;
    bit_cnt = '0;
    stored_cnt = 0;
    run_cnt = '0;
    framed_samples = 0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 21;
    recv_idle_pct = 82;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_while_searching();
    test_run_of_ones_end();
    test_sync_inside_packet();
    test_max_length_end();
    test_random(21, 82, 40);
    test_random(82, 21, 40);
    test_random(0, 0, 40);

    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
